/* hdl/ssfw_pkg.sv */
`timescale 1ns / 1ps

package ssfw_pkg;

    localparam int DIGIT_MAX   = 8;
    localparam int SEG_COUNT   = 8;
    localparam int WRITE_COUNT = 2 * SEG_COUNT;
    localparam int IDX_W       = $clog2(WRITE_COUNT);
    localparam int SEG_IDX_W   = $clog2(SEG_COUNT);

    localparam logic [7:0]       BASE_ADDRESS = 8'hC0;
    localparam logic [IDX_W-1:0] LAST_INDEX   = IDX_W'(WRITE_COUNT - 1);

    typedef logic [3:0] t_digit;
    typedef logic [7:0] t_code;

    typedef struct packed {
        logic [SEG_COUNT-1:0][7:0] seg;
        logic [SEG_COUNT-1:0]      led;
    } t_frame;

    localparam t_code SEG_TABLE [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
    };

    function automatic t_code seg_decode(input t_digit digit);
        return SEG_TABLE[digit];
    endfunction

endpackage

/* hdl/ssfw_lane.sv */
`timescale 1ns / 1ps

module ssfw_lane (
    input  logic                i_clk,
    input  logic                i_load,
    input  ssfw_pkg::t_digit    i_digit,
    output ssfw_pkg::t_code     o_code
);

    ssfw_pkg::t_code r_code;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= ssfw_pkg::seg_decode(i_digit);
        end
    end

    assign o_code = r_code;

endmodule

/* hdl/ssfw_merge.sv */
`timescale 1ns / 1ps

module ssfw_merge #(
    parameter int DIGIT_COUNT = 8
) (
    input  ssfw_pkg::t_code                    i_code [DIGIT_COUNT],
    input  logic [ssfw_pkg::SEG_COUNT-1:0]     i_led,
    output ssfw_pkg::t_frame                   o_frame
);

    always_comb begin
        o_frame     = '0;
        o_frame.led = i_led;
        for (int s = 0; s < ssfw_pkg::SEG_COUNT; s++) begin
            for (int j = 0; j < DIGIT_COUNT; j++) begin
                o_frame.seg[s][j] = i_code[j][s];
            end
        end
    end

endmodule

/* hdl/ssfw_writer.sv */
`timescale 1ns / 1ps

module ssfw_writer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_frame_valid,
    input  ssfw_pkg::t_frame  i_frame,
    output logic              o_frame_take,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_grid_address,
    output logic [7:0]        o_write_data,
    output logic              o_last_write
);

    ssfw_pkg::t_frame                r_frame;
    logic                            r_act_valid;
    logic [ssfw_pkg::IDX_W-1:0]      r_idx;
    logic                            r_o_valid;
    logic [7:0]                      r_o_addr;
    logic [7:0]                      r_o_data;
    logic                            r_o_last;

    logic                            out_free;
    logic                            act_done;
    logic [ssfw_pkg::SEG_IDX_W-1:0]  seg_sel;
    logic [7:0]                      n_data;

    assign out_free     = !r_o_valid || i_ready;
    assign act_done     = out_free && r_act_valid && (r_idx == ssfw_pkg::LAST_INDEX);
    assign o_frame_take = i_frame_valid && (!r_act_valid || act_done);
    assign seg_sel      = r_idx[ssfw_pkg::IDX_W-1:1];
    assign n_data       = r_idx[0] ? {7'b0, r_frame.led[seg_sel]} : r_frame.seg[seg_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
            r_idx       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (out_free) begin
                r_o_valid <= r_act_valid;
                if (r_act_valid) begin
                    r_o_addr <= ssfw_pkg::BASE_ADDRESS + 8'(r_idx);
                    r_o_data <= n_data;
                    r_o_last <= (r_idx == ssfw_pkg::LAST_INDEX);
                    r_idx    <= r_idx + 1'b1;
                end
            end
            if (o_frame_take) begin
                r_act_valid <= 1'b1;
                r_frame     <= i_frame;
            end else if (act_done) begin
                r_act_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_grid_address = r_o_addr;
    assign o_write_data   = r_o_data;
    assign o_last_write   = r_o_last;

endmodule

/* hdl/seven_segment_frame_writer_top.sv */
`timescale 1ns / 1ps

// Seven-segment frame writer.
// Input channel (i_valid / o_ready): one item carries eight hex digits and an
// LED mask. Output channel (o_valid / i_ready): sixteen display-memory writes
// per item, addresses 0xC0..0xCF in order, the last one flagged by
// o_last_write. Even addresses carry the transposed segment byte (bit j is a
// segment of digit j), odd addresses carry one LED bit in bit 0.
// Digits at or above DIGIT_COUNT have no decode lane and read as dark.
// When the writer is idle, an accepted item is registered in the lane registers,
// then in the writer's frame register, and then its first write on the outputs.
// Throughput: one write per cycle while i_ready is high, sixteen writes per item;
// the output sequencer that steps through the sixteen writes sets that rate.
// A second item is taken into the lane registers while the current frame is
// still being written, and moves on as the last write of that frame leaves.
// When the receiver holds i_ready low, the current write stays on the outputs
// and the sequencer holds; o_ready drops once the lane registers are full.
// Reset clears all valid state; no write is in flight after reset.

module seven_segment_frame_writer_top #(
    parameter int DIGIT_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_digit_0,
    input  logic [3:0] i_digit_1,
    input  logic [3:0] i_digit_2,
    input  logic [3:0] i_digit_3,
    input  logic [3:0] i_digit_4,
    input  logic [3:0] i_digit_5,
    input  logic [3:0] i_digit_6,
    input  logic [3:0] i_digit_7,
    input  logic [7:0] i_led_mask,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_grid_address,
    output logic [7:0] o_write_data,
    output logic       o_last_write
);

    ssfw_pkg::t_digit  w_digit [ssfw_pkg::DIGIT_MAX];
    ssfw_pkg::t_code   w_code  [DIGIT_COUNT];
    ssfw_pkg::t_frame  w_frame;
    logic [7:0]        r_led;
    logic              r_pend_valid;
    logic              in_accept;
    logic              frame_take;

    assign w_digit[0] = i_digit_0;
    assign w_digit[1] = i_digit_1;
    assign w_digit[2] = i_digit_2;
    assign w_digit[3] = i_digit_3;
    assign w_digit[4] = i_digit_4;
    assign w_digit[5] = i_digit_5;
    assign w_digit[6] = i_digit_6;
    assign w_digit[7] = i_digit_7;

    assign o_ready   = !r_pend_valid || frame_take;
    assign in_accept = i_valid && o_ready;

    for (genvar j = 0; j < DIGIT_COUNT; j++) begin : g_lane
        ssfw_lane u_lane (
            .i_clk   (i_clk),
            .i_load  (in_accept),
            .i_digit (w_digit[j]),
            .o_code  (w_code[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_pend_valid <= 1'b1;
            end else if (frame_take) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_led <= i_led_mask;
        end
    end

    ssfw_merge #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_merge (
        .i_code  (w_code),
        .i_led   (r_led),
        .o_frame (w_frame)
    );

    ssfw_writer u_writer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_valid  (r_pend_valid),
        .i_frame        (w_frame),
        .o_frame_take   (frame_take),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_grid_address (o_grid_address),
        .o_write_data   (o_write_data),
        .o_last_write   (o_last_write)
    );

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_pend_valid)
        else $error("accepted item not held in lane registers");

    a_addr_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_write) |=>
            (o_valid && o_grid_address == $past(o_grid_address) + 8'd1))
        else $error("write sequence broke inside a frame");

    a_led_bit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_grid_address[0]) |-> (o_write_data[7:1] == 7'd0))
        else $error("LED write carries more than one bit");

    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_write) |-> (o_grid_address[3:0] == 4'hF))
        else $error("last write flagged at wrong address");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int DIGITS = 8;
    localparam int ERROR_REPORT_MAX = 10;
    localparam int RANDOM_FRAMES = 240;

    localparam logic [7:0] HEX_SEGMENTS [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
    };

    typedef struct packed {
        logic [7:0] address;
        logic [7:0] data;
        logic       last;
    } t_grid_write;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_ready;
    logic [7:0][3:0] frame_digits = '0;
    logic [7:0]      frame_leds = '0;
    logic            o_valid;
    logic            i_ready = 1'b0;
    logic [7:0]      o_grid_address;
    logic [7:0]      o_write_data;
    logic            o_last_write;

    t_grid_write expected_writes [$];
    t_grid_write head_write;
    int          write_mismatches = 0;
    int          burst_left = 0;
    int          rx_hold = 0;
    bit          tx_gaps_on = 1'b0;
    bit          rx_stalls_on = 1'b0;

    seven_segment_frame_writer_top #(
        .DIGIT_COUNT(DIGITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_digit_0(frame_digits[0]),
        .i_digit_1(frame_digits[1]),
        .i_digit_2(frame_digits[2]),
        .i_digit_3(frame_digits[3]),
        .i_digit_4(frame_digits[4]),
        .i_digit_5(frame_digits[5]),
        .i_digit_6(frame_digits[6]),
        .i_digit_7(frame_digits[7]),
        .i_led_mask(frame_leds),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_grid_address(o_grid_address),
        .o_write_data(o_write_data),
        .o_last_write(o_last_write)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void queue_frame_writes(input logic [7:0][3:0] digits,
                                               input logic [7:0] leds);
        logic [7:0]  codes [8];
        t_grid_write wr;
        int          k;
        int          j;
        for (j = 0; j < 8; j++) begin
            codes[j] = HEX_SEGMENTS[digits[j]];
        end
        for (k = 0; k < ssfw_pkg::WRITE_COUNT; k++) begin
            wr.address = ssfw_pkg::BASE_ADDRESS + 8'(k);
            wr.data = '0;
            if (k % 2 == 0) begin
                for (j = 0; j < 8 && j < DIGITS; j++) begin
                    wr.data[j] = codes[j][k / 2];
                end
            end else begin
                wr.data[0] = leds[k / 2];
            end
            wr.last = (k == ssfw_pkg::WRITE_COUNT - 1);
            expected_writes.push_back(wr);
        end
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got, input logic [7:0] address);
        if (got !== want) begin
            write_mismatches++;
            if (write_mismatches <= ERROR_REPORT_MAX) begin
                $display("%0t: write 0x%h %s mismatch: expected 0x%h, got 0x%h",
                         $realtime, address, field, want, got);
            end
        end
    endfunction

    always @(negedge i_clk) begin
        if (!rx_stalls_on) begin
            i_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            rx_hold <= $urandom_range(11, 0);
            i_ready <= ($urandom_range(9, 0) < 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_writes.size() == 0) begin
                write_mismatches++;
                if (write_mismatches <= ERROR_REPORT_MAX) begin
                    $display("%0t: unexpected write 0x%h data 0x%h last %b",
                             $realtime, o_grid_address, o_write_data, o_last_write);
                end
            end else begin
                head_write = expected_writes.pop_front();
                check_field("address", head_write.address, o_grid_address,
                            head_write.address);
                check_field("data", head_write.data, o_write_data, head_write.address);
                check_field("last", {7'b0, head_write.last}, {7'b0, o_last_write},
                            head_write.address);
            end
        end
    end

    task automatic send_frame(input logic [7:0][3:0] digits, input logic [7:0] leds);
        int gap;
        if (tx_gaps_on && burst_left == 0) begin
            gap = $urandom_range(6, 1);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(8, 1);
        end
        @(negedge i_clk);
        frame_digits <= digits;
        frame_leds <= leds;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        queue_frame_writes(digits, leds);
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic release_sender();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain_writes();
        while (expected_writes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extreme_frames();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        send_frame('0, 8'h00);
        send_frame({8{4'hf}}, 8'hff);
        send_frame(32'h7654_3210, 8'h55);
        send_frame(32'hfedc_ba98, 8'haa);
        send_frame(32'h0123_4567, 8'hf0);
        send_frame(32'h89ab_cdef, 8'h0f);
    endtask

    task automatic test_digit_positions();
        logic [7:0][3:0] digits;
        int              p;
        rx_stalls_on = 1'b1;
        for (p = 0; p < 8; p++) begin
            digits = {8{4'h1}};
            digits[p] = 4'h8;
            send_frame(digits, 8'(1 << p));
        end
    endtask

    task automatic test_drain_pause();
        int n;
        tx_gaps_on = 1'b1;
        for (n = 0; n < 3; n++) begin
            send_frame($urandom, 8'($urandom));
        end
        release_sender();
        drain_writes();
        for (n = 0; n < 3; n++) begin
            send_frame($urandom, 8'($urandom));
        end
    endtask

    task automatic test_random_frames();
        logic [7:0][3:0] digits;
        logic [7:0]      leds;
        int              n;
        int              stretch;
        stretch = 0;
        for (n = 0; n < RANDOM_FRAMES; n++) begin
            if (stretch == 0) begin
                stretch = $urandom_range(50, 20);
                tx_gaps_on = 1'($urandom_range(1, 0));
                rx_stalls_on = 1'($urandom_range(1, 0));
            end
            stretch--;
            digits = $urandom;
            leds = 8'($urandom);
            case ($urandom_range(9, 0))
                0: digits = '0;
                1: digits = {8{4'hf}};
                default: ;
            endcase
            send_frame(digits, leds);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extreme_frames();
        test_digit_positions();
        test_drain_pause();
        test_random_frames();
        release_sender();
        drain_writes();
        repeat (20) @(posedge i_clk);
        if (write_mismatches == 0 && expected_writes.size() == 0) begin
            $display("seven_segment_frame_writer_top regression: pass");
        end else begin
            $display("seven_segment_frame_writer_top regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("seven_segment_frame_writer_top regression: fail");
        $finish;
    end

endmodule
